// ----- rtl/bdtc_pkg.sv -----
// Shared types, constants and helper functions for the BCD date-time converter.
// Used by the controller, the datapath and the top level; depends on nothing.
package bdtc_pkg;

  localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
  localparam logic [31:0] SECS_PER_MIN  = 32'd60;
  localparam logic [31:0] DAYS_PER_WEEK = 32'd7;

  localparam logic [15:0] DAYS_LIMIT    = 16'd36525;  // 2100-01-01
  localparam logic [15:0] DAYS_PER_QUAD = 16'd1461;   // leap year plus three common years
  localparam logic [15:0] WDAY_BASE     = 16'd6;      // 2000-01-01 fell on a Saturday

  // Reciprocals for division by constants: floor(a / d) = (a * M) >> k, exact for
  // every operand of the width noted; the power-of-two part of d is dropped first.
  localparam logic [25:0] RECIP_DAY  = 26'd50903317;  // d = 675, 25-bit a, k = 35
  localparam logic [13:0] RECIP_HOUR = 14'd9321;      // d = 225, 13-bit a, k = 21
  localparam logic [10:0] RECIP_MIN  = 11'd1093;      // d = 15, 10-bit a, k = 14
  localparam logic [16:0] RECIP_WDAY = 17'd74899;     // d = 7, 16-bit a, k = 19

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ENC_DAYS,
    ST_ENC_MUL,
    ST_ENC_SUM,
    ST_DIV_DAY,
    ST_REM_DAY,
    ST_DIV_HOUR,
    ST_REM_HOUR,
    ST_DIV_MIN,
    ST_REM_MIN,
    ST_DIV_WDAY,
    ST_YEAR_INIT,
    ST_YEAR4,
    ST_YEAR1,
    ST_MONTH,
    ST_FINISH
  } bdtc_state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_ENC_DAYS,
    OP_ENC_MUL,
    OP_ENC_SUM,
    OP_DIV_DAY,
    OP_REM_DAY,
    OP_DIV_HOUR,
    OP_REM_HOUR,
    OP_DIV_MIN,
    OP_REM_MIN,
    OP_DIV_WDAY,
    OP_YEAR_INIT,
    OP_YEAR4,
    OP_YEAR1,
    OP_MONTH,
    OP_FINISH
  } bdtc_op_t;

  typedef struct packed {
    bdtc_op_t op;
  } bdtc_cmd_t;

  typedef struct packed {
    logic year4_go;
    logic year1_go;
    logic month_go;
  } bdtc_status_t;

  function automatic logic [7:0] bcd_dec(input logic [7:0] b);
    return 8'(b[7:4]) * 8'd10 + 8'(b[3:0]);
  endfunction

  // Two-digit BCD of a value below 100; tens come from x*205 >> 11.
  function automatic logic [7:0] bin_to_bcd(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  tens;
    logic [6:0]  ones;
    p    = 15'(v) * 15'd205;
    tens = p[14:11];
    ones = v - 7'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

  function automatic logic [4:0] month_days(input logic leap, input logic [3:0] m);
    logic [4:0] d;
    case (m)
      4'd1:    d = leap ? 5'd29 : 5'd28;
      4'd3:    d = 5'd30;
      4'd5:    d = 5'd30;
      4'd8:    d = 5'd30;
      4'd10:   d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

  // Days before the first of a month (1..12) in a common year.
  function automatic logic [8:0] cum_days(input logic [7:0] mon);
    logic [8:0] d;
    case (mon)
      8'd2:    d = 9'd31;
      8'd3:    d = 9'd59;
      8'd4:    d = 9'd90;
      8'd5:    d = 9'd120;
      8'd6:    d = 9'd151;
      8'd7:    d = 9'd181;
      8'd8:    d = 9'd212;
      8'd9:    d = 9'd243;
      8'd10:   d = 9'd273;
      8'd11:   d = 9'd304;
      8'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/bcd_datetime_timestamp_converter.sv -----
// Converts between BCD real-time-clock date-time and seconds since 2000-01-01.
// Top level: joins bdtc_ctrl and bdtc_dp; uses bdtc_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): one request per handshake. in_req_type 0
//   turns the BCD bytes into a timestamp, 1 turns in_stamp_in into BCD fields and
//   a weekday. Result channel (out_valid / out_stall): one result per request.
//   A request is taken only while the block is idle; in_stall is high from the
//   cycle after acceptance until the result has been loaded into the output
//   register. A waiting result does not block the next request.
//   Order of work, acceptance to out_valid: for req_type 0, the encode steps and the
//   result load. For req_type 1, reciprocal-multiply quotients and remainders (days,
//   hours, minutes, weekday), a step to start the calendar walk, then one step at a
//   time: at most 24 four-year steps, 3 single years and 11 months in range (25
//   four-year steps and 11 months past 2099), a step to leave each of those loops
//   and the result load. The block works on one request at a time.
//   If out_stall holds a previous result, the finished request waits in place.
//   Reset (rst_n low, synchronous) returns to idle and drops any pending result.
module bcd_datetime_timestamp_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [31:0] in_stamp_in,
  input  logic [7:0]  in_sec_in,
  input  logic [7:0]  in_min_in,
  input  logic [7:0]  in_hour_in,
  input  logic [7:0]  in_day_in,
  input  logic [7:0]  in_month_in,
  input  logic [7:0]  in_year_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_stamp_out,
  output logic [6:0]  out_sec_out,
  output logic [6:0]  out_min_out,
  output logic [5:0]  out_hour_out,
  output logic [5:0]  out_day_out,
  output logic [4:0]  out_month_out,
  output logic [7:0]  out_year_out,
  output logic [2:0]  out_weekday_out,
  output logic        out_out_of_range
);
  import bdtc_pkg::*;

  bdtc_cmd_t    cmd;
  bdtc_status_t status;

  bdtc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .cmd         (cmd)
  );

  bdtc_dp u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .status           (status),
    .in_req_type      (in_req_type),
    .in_stamp_in      (in_stamp_in),
    .in_sec_in        (in_sec_in),
    .in_min_in        (in_min_in),
    .in_hour_in       (in_hour_in),
    .in_day_in        (in_day_in),
    .in_month_in      (in_month_in),
    .in_year_in       (in_year_in),
    .out_stamp_out    (out_stamp_out),
    .out_sec_out      (out_sec_out),
    .out_min_out      (out_min_out),
    .out_hour_out     (out_hour_out),
    .out_day_out      (out_day_out),
    .out_month_out    (out_month_out),
    .out_year_out     (out_year_out),
    .out_weekday_out  (out_weekday_out),
    .out_out_of_range (out_out_of_range)
  );

`ifndef NO_ASSERTIONS
  // a request, once taken, raises in_stall in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while previous one in progress");

  // a new result only comes out of a busy phase
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request in progress");

  // rejected requests carry zero stamp, year and weekday fields
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |->
      (out_stamp_out == 32'd0) && (out_year_out == 8'd0) && (out_weekday_out == 3'd0))
    else $error("out-of-range result with nonzero fields");

  a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_weekday_out <= 3'd6))
    else $error("weekday beyond Saturday");
`endif

endmodule

// ----- rtl/bdtc_ctrl.sv -----
// Sequencer for the BCD date-time converter: handshakes and phase order.
// Drives the datapath through bdtc_cmd_t and reads bdtc_status_t; uses bdtc_pkg.
module bdtc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_req_type,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  bdtc_pkg::bdtc_status_t status,
  output bdtc_pkg::bdtc_cmd_t   cmd
);
  import bdtc_pkg::*;

  bdtc_state_t       state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = OP_NONE;
    in_stall      = (state_r != ST_IDLE) || !rst_n;

    case (state_r)
      ST_IDLE: begin
        if (in_valid && rst_n) begin
          cmd.op = OP_CAPTURE;
          if (in_req_type) begin
            state_nxt = ST_DIV_DAY;
          end else begin
            state_nxt = ST_ENC_DAYS;
          end
        end
      end
      ST_ENC_DAYS: begin
        cmd.op    = OP_ENC_DAYS;
        state_nxt = ST_ENC_MUL;
      end
      ST_ENC_MUL: begin
        cmd.op    = OP_ENC_MUL;
        state_nxt = ST_ENC_SUM;
      end
      ST_ENC_SUM: begin
        cmd.op    = OP_ENC_SUM;
        state_nxt = ST_FINISH;
      end
      ST_DIV_DAY: begin
        cmd.op    = OP_DIV_DAY;
        state_nxt = ST_REM_DAY;
      end
      ST_REM_DAY: begin
        cmd.op    = OP_REM_DAY;
        state_nxt = ST_DIV_HOUR;
      end
      ST_DIV_HOUR: begin
        cmd.op    = OP_DIV_HOUR;
        state_nxt = ST_REM_HOUR;
      end
      ST_REM_HOUR: begin
        cmd.op    = OP_REM_HOUR;
        state_nxt = ST_DIV_MIN;
      end
      ST_DIV_MIN: begin
        cmd.op    = OP_DIV_MIN;
        state_nxt = ST_REM_MIN;
      end
      ST_REM_MIN: begin
        cmd.op    = OP_REM_MIN;
        state_nxt = ST_DIV_WDAY;
      end
      ST_DIV_WDAY: begin
        cmd.op    = OP_DIV_WDAY;
        state_nxt = ST_YEAR_INIT;
      end
      ST_YEAR_INIT: begin
        cmd.op    = OP_YEAR_INIT;
        state_nxt = ST_YEAR4;
      end
      ST_YEAR4: begin
        if (status.year4_go) cmd.op = OP_YEAR4;
        else state_nxt = ST_YEAR1;
      end
      ST_YEAR1: begin
        if (status.year1_go) cmd.op = OP_YEAR1;
        else state_nxt = ST_MONTH;
      end
      ST_MONTH: begin
        if (status.month_go) cmd.op = OP_MONTH;
        else state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register is free or drains this cycle
        if (!out_valid_r || !out_stall) begin
          cmd.op        = OP_FINISH;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/bdtc_dp.sv -----
// Datapath of the BCD date-time converter: captured request, reciprocal-multiply
// division by constants, year/month walk and output registers. Uses bdtc_pkg.
module bdtc_dp (
  input  logic                   clk,
  input  bdtc_pkg::bdtc_cmd_t    cmd,
  output bdtc_pkg::bdtc_status_t status,
  input  logic                   in_req_type,
  input  logic [31:0]            in_stamp_in,
  input  logic [7:0]             in_sec_in,
  input  logic [7:0]             in_min_in,
  input  logic [7:0]             in_hour_in,
  input  logic [7:0]             in_day_in,
  input  logic [7:0]             in_month_in,
  input  logic [7:0]             in_year_in,
  output logic [31:0]            out_stamp_out,
  output logic [6:0]             out_sec_out,
  output logic [6:0]             out_min_out,
  output logic [5:0]             out_hour_out,
  output logic [5:0]             out_day_out,
  output logic [4:0]             out_month_out,
  output logic [7:0]             out_year_out,
  output logic [2:0]             out_weekday_out,
  output logic                   out_out_of_range
);
  import bdtc_pkg::*;

  // request
  logic        req_r;
  logic [7:0]  sec_b_r, min_b_r, hour_b_r, day_b_r, mon_b_r, year_b_r;

  // working registers
  logic [31:0] num_r;
  logic [12:0] quo_r;
  logic [15:0] days_r;
  logic [19:0] tpart_r;
  logic [32:0] prod_r;
  logic [4:0]  hour_r;
  logic [5:0]  min_r, sec_r;
  logic [2:0]  wday_r;
  logic [15:0] left_r;
  logic [6:0]  y_r;
  logic [3:0]  m_r;

  // output registers
  logic [31:0] stamp_o_r;
  logic [6:0]  sec_o_r, min_o_r;
  logic [5:0]  hour_o_r, day_o_r;
  logic [4:0]  month_o_r;
  logic [7:0]  year_o_r;
  logic [2:0]  wday_o_r;
  logic        oor_o_r;

  logic [7:0]  sec_d, min_d, hour_d, day_d, mon_d, yr_d;
  logic        enc_bad, dec_bad, bad;
  logic        leap_adj;
  logic [16:0] enc_days;
  logic [19:0] enc_tpart;
  logic [33:0] enc_sum;
  logic [50:0] day_prod;
  logic [25:0] hr_prod;
  logic [19:0] mn_prod;
  logic [31:0] wk_prod;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic [7:0]  sec_bcd, min_bcd, hour_bcd, day_bcd, mon_bcd, year_bcd;

  always_comb begin
    sec_d    = bcd_dec(sec_b_r);
    min_d    = bcd_dec(min_b_r);
    hour_d   = bcd_dec(hour_b_r);
    day_d    = bcd_dec(day_b_r);
    mon_d    = bcd_dec(mon_b_r);
    yr_d     = bcd_dec(year_b_r);
    enc_bad  = (mon_d == 8'd0) || (mon_d > 8'd12) || (day_d == 8'd0);
    dec_bad  = (days_r >= DAYS_LIMIT);
    bad      = req_r ? dec_bad : enc_bad;
    leap_adj = (yr_d[1:0] == 2'b00) && (mon_d > 8'd2);

    enc_days = 17'(yr_d) * 17'd365 + 17'((9'(yr_d) + 9'd3) >> 2)
             + 17'(cum_days(mon_d)) + 17'(leap_adj) + 17'(day_d) - 17'd1;
    enc_tpart = 20'(hour_d) * 20'(SECS_PER_HOUR) + 20'(min_d) * 20'(SECS_PER_MIN)
              + 20'(sec_d);
    enc_sum  = 34'(prod_r) + 34'(tpart_r);

    // quotients: stamp / 86400, rem / 3600, rem / 60, (days + 6) / 7
    day_prod = 51'(num_r[31:7]) * 51'(RECIP_DAY);
    hr_prod  = 26'(num_r[16:4]) * 26'(RECIP_HOUR);
    mn_prod  = 20'(num_r[11:2]) * 20'(RECIP_MIN);
    wk_prod  = 32'(num_r[15:0]) * 32'(RECIP_WDAY);

    ylen     = (y_r[1:0] == 2'b00) ? 9'd366 : 9'd365;
    mlen     = month_days(y_r[1:0] == 2'b00, m_r);

    status.year4_go = (y_r <= 7'd96) && (left_r >= DAYS_PER_QUAD);
    status.year1_go = (y_r < 7'd100) && (left_r >= 16'(ylen));
    status.month_go = (m_r < 4'd11) && (left_r >= 16'(mlen));

    sec_bcd  = bin_to_bcd(7'(sec_r));
    min_bcd  = bin_to_bcd(7'(min_r));
    hour_bcd = bin_to_bcd(7'(hour_r));
    day_bcd  = bin_to_bcd(7'(left_r + 16'd1));
    mon_bcd  = bin_to_bcd(7'(m_r) + 7'd1);
    year_bcd = bin_to_bcd(y_r);
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        req_r    <= in_req_type;
        sec_b_r  <= in_sec_in;
        min_b_r  <= in_min_in;
        hour_b_r <= in_hour_in;
        day_b_r  <= in_day_in;
        mon_b_r  <= in_month_in;
        year_b_r <= in_year_in;
        num_r    <= in_stamp_in;
      end
      OP_ENC_DAYS: begin
        days_r  <= enc_days[15:0];
        tpart_r <= enc_tpart;
      end
      OP_ENC_MUL: begin
        prod_r <= 33'(days_r) * 33'(SECS_PER_DAY);
      end
      OP_ENC_SUM: begin
        // saturate a sum past 32 bits
        num_r <= (enc_sum[33:32] != 2'b00) ? '1 : enc_sum[31:0];
      end
      OP_DIV_DAY: begin
        days_r <= day_prod[50:35];
      end
      OP_REM_DAY: begin
        num_r <= num_r - 32'(days_r) * SECS_PER_DAY;
      end
      OP_DIV_HOUR: begin
        hour_r <= hr_prod[25:21];
      end
      OP_REM_HOUR: begin
        num_r <= num_r - 32'(hour_r) * SECS_PER_HOUR;
      end
      OP_DIV_MIN: begin
        min_r <= mn_prod[19:14];
      end
      OP_REM_MIN: begin
        sec_r <= 6'(num_r - 32'(min_r) * SECS_PER_MIN);
        num_r <= 32'(days_r) + 32'(WDAY_BASE);
      end
      OP_DIV_WDAY: begin
        quo_r <= wk_prod[31:19];
      end
      OP_YEAR_INIT: begin
        wday_r <= 3'(num_r - 32'(quo_r) * DAYS_PER_WEEK);
        left_r <= days_r;
        y_r    <= '0;
        m_r    <= '0;
      end
      OP_YEAR4: begin
        left_r <= left_r - DAYS_PER_QUAD;
        y_r    <= y_r + 7'd4;
      end
      OP_YEAR1: begin
        left_r <= left_r - 16'(ylen);
        y_r    <= y_r + 7'd1;
      end
      OP_MONTH: begin
        left_r <= left_r - 16'(mlen);
        m_r    <= m_r + 4'd1;
      end
      OP_FINISH: begin
        oor_o_r <= bad;
        if (bad || req_r) stamp_o_r <= '0;
        else stamp_o_r <= num_r;
        if (bad || !req_r) begin
          sec_o_r   <= '0;
          min_o_r   <= '0;
          hour_o_r  <= '0;
          day_o_r   <= '0;
          month_o_r <= '0;
          year_o_r  <= '0;
          wday_o_r  <= '0;
        end else begin
          sec_o_r   <= sec_bcd[6:0];
          min_o_r   <= min_bcd[6:0];
          hour_o_r  <= hour_bcd[5:0];
          day_o_r   <= day_bcd[5:0];
          month_o_r <= mon_bcd[4:0];
          year_o_r  <= year_bcd;
          wday_o_r  <= wday_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_stamp_out    = stamp_o_r;
  assign out_sec_out      = sec_o_r;
  assign out_min_out      = min_o_r;
  assign out_hour_out     = hour_o_r;
  assign out_day_out      = day_o_r;
  assign out_month_out    = month_o_r;
  assign out_year_out     = year_o_r;
  assign out_weekday_out  = wday_o_r;
  assign out_out_of_range = oor_o_r;

endmodule

// ----- tb/clock_check_pkg.sv -----
`timescale 1ns / 100ps
// Request/result types and the date-time predictor with its scoreboard for the
// BCD date-time converter testbench. Depends on nothing.
package clock_check_pkg;

  typedef enum logic {
    REQ_TO_STAMP = 1'b0,
    REQ_TO_DATE  = 1'b1
  } req_kind_t;

  localparam int unsigned SECS_DAY      = 86400;
  localparam int unsigned SECS_HOUR     = 3600;
  localparam int unsigned SECS_MIN      = 60;
  localparam int unsigned DAY_COUNT_END = 36525;  // 2100-01-01
  localparam int unsigned REPORT_MAX    = 10;

  typedef struct packed {
    req_kind_t   kind;
    logic [31:0] stamp;
    logic [7:0]  sec;
    logic [7:0]  min;
    logic [7:0]  hour;
    logic [7:0]  day;
    logic [7:0]  month;
    logic [7:0]  year;
  } clock_req_t;

  typedef struct packed {
    logic [31:0] stamp;
    logic [6:0]  sec;
    logic [6:0]  min;
    logic [5:0]  hour;
    logic [5:0]  day;
    logic [4:0]  month;
    logic [7:0]  year;
    logic [2:0]  wday;
    logic        oor;
  } clock_result_t;

  function automatic logic [7:0] to_bcd(input int unsigned v);
    return 8'((((v / 10) % 10) << 4) | (v % 10));
  endfunction

  // m0 counts from 0 = January; year is the two-digit offset from 2000
  function automatic int unsigned month_length(input int unsigned y, input int unsigned m0);
    case (m0 % 12)
      1:           return (y % 4 == 0) ? 29 : 28;
      3, 5, 8, 10: return 30;
      default:     return 31;
    endcase
  endfunction

  class date_stamp_scoreboard;
    clock_result_t awaited_results[$];
    int unsigned   mismatches;
    int unsigned   checked;

    function new();
      mismatches = 0;
      checked    = 0;
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction

    function int unsigned bcd_value(input logic [7:0] b);
      return int'(b[7:4]) * 10 + int'(b[3:0]);
    endfunction

    function clock_result_t convert_request(input clock_req_t req);
      clock_result_t     res;
      int unsigned       s, mi, h, d, mo, y, m, days32, rem, left;
      longint unsigned   days, total;
      res = '0;
      if (req.kind == REQ_TO_STAMP) begin
        s  = bcd_value(req.sec);
        mi = bcd_value(req.min);
        h  = bcd_value(req.hour);
        d  = bcd_value(req.day);
        mo = bcd_value(req.month);
        y  = bcd_value(req.year);
        if (mo == 0 || mo > 12 || d == 0) begin
          res.oor = 1'b1;
          return res;
        end
        days = 64'(y) * 365 + 64'((y + 3) / 4);
        for (m = 0; m + 1 < mo; m++)
          days += 64'(month_length(y, m));
        days += 64'(d - 1);
        total = days * SECS_DAY + 64'(h) * SECS_HOUR + 64'(mi) * SECS_MIN + 64'(s);
        // saturate instead of wrapping
        res.stamp = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
      end else begin
        days32 = req.stamp / SECS_DAY;
        rem    = req.stamp % SECS_DAY;
        if (days32 >= DAY_COUNT_END) begin
          res.oor = 1'b1;
          return res;
        end
        left = days32;
        y    = 0;
        m    = 0;
        while (y < 100 && left >= ((y % 4 == 0) ? 366 : 365)) begin
          left -= (y % 4 == 0) ? 366 : 365;
          y++;
        end
        while (m < 11 && left >= month_length(y, m)) begin
          left -= month_length(y, m);
          m++;
        end
        res.sec   = 7'(to_bcd(rem % 60));
        res.min   = 7'(to_bcd((rem / 60) % 60));
        res.hour  = 6'(to_bcd(rem / 3600));
        res.day   = 6'(to_bcd(left + 1));
        res.month = 5'(to_bcd(m + 1));
        res.year  = to_bcd(y);
        // 2000-01-01 was a Saturday
        res.wday  = 3'((days32 + 6) % 7);
      end
      return res;
    endfunction

    function string show(input clock_result_t r);
      return $sformatf("stamp=%h time=%h:%h:%h date=%h-%h-%h wday=%0d oor=%b",
                       r.stamp, r.hour, r.min, r.sec, r.year, r.month, r.day,
                       r.wday, r.oor);
    endfunction

    function void flag(input string what);
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("[%0t] mismatch: %s", $time, what);
    endfunction

    function void note_request(input clock_req_t req);
      awaited_results.push_back(convert_request(req));
    endfunction

    function void check_result(input clock_result_t got);
      clock_result_t want;
      if (awaited_results.size() == 0) begin
        flag({"result with no request pending: ", show(got)});
        return;
      end
      want = awaited_results.pop_front();
      if (got !== want)
        flag($sformatf("result %0d\n  expected %s\n  actual   %s",
                       checked, show(want), show(got)));
      checked++;
    endfunction
  endclass

endpackage

// ----- tb/tb_bcd_datetime_timestamp_converter.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for bcd_datetime_timestamp_converter: directed and
// random requests in both directions. Depends on clock_check_pkg and the RTL.
module tb_bcd_datetime_timestamp_converter;
  import clock_check_pkg::*;

  localparam int RANDOM_REQUESTS = 900;
  localparam int STEADY_REQUESTS = 150;  // no sender gaps at the start
  localparam int WATCHDOG_MAX    = 3000;
  localparam int TAIL_CYCLES     = 120;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_req_type = 1'b0;
  logic [31:0] in_stamp_in = '0;
  logic [7:0]  in_sec_in = '0;
  logic [7:0]  in_min_in = '0;
  logic [7:0]  in_hour_in = '0;
  logic [7:0]  in_day_in = '0;
  logic [7:0]  in_month_in = '0;
  logic [7:0]  in_year_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_stamp_out;
  logic [6:0]  out_sec_out;
  logic [6:0]  out_min_out;
  logic [5:0]  out_hour_out;
  logic [5:0]  out_day_out;
  logic [4:0]  out_month_out;
  logic [7:0]  out_year_out;
  logic [2:0]  out_weekday_out;
  logic        out_out_of_range;

  logic [15:0]   cycle_count = '0;
  int unsigned   idle_cycles = 0;
  clock_req_t    req_on_bus;
  clock_result_t result_on_bus;
  date_stamp_scoreboard board;

  bcd_datetime_timestamp_converter uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_stamp_in      (in_stamp_in),
    .in_sec_in        (in_sec_in),
    .in_min_in        (in_min_in),
    .in_hour_in       (in_hour_in),
    .in_day_in        (in_day_in),
    .in_month_in      (in_month_in),
    .in_year_in       (in_year_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_stamp_out    (out_stamp_out),
    .out_sec_out      (out_sec_out),
    .out_min_out      (out_min_out),
    .out_hour_out     (out_hour_out),
    .out_day_out      (out_day_out),
    .out_month_out    (out_month_out),
    .out_year_out     (out_year_out),
    .out_weekday_out  (out_weekday_out),
    .out_out_of_range (out_out_of_range)
  );

  always #2 clk = ~clk;

  always_comb begin
    req_on_bus.kind  = req_kind_t'(in_req_type);
    req_on_bus.stamp = in_stamp_in;
    req_on_bus.sec   = in_sec_in;
    req_on_bus.min   = in_min_in;
    req_on_bus.hour  = in_hour_in;
    req_on_bus.day   = in_day_in;
    req_on_bus.month = in_month_in;
    req_on_bus.year  = in_year_in;
    result_on_bus.stamp = out_stamp_out;
    result_on_bus.sec   = out_sec_out;
    result_on_bus.min   = out_min_out;
    result_on_bus.hour  = out_hour_out;
    result_on_bus.day   = out_day_out;
    result_on_bus.month = out_month_out;
    result_on_bus.year  = out_year_out;
    result_on_bus.wday  = out_weekday_out;
    result_on_bus.oor   = out_out_of_range;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      board.note_request(req_on_bus);
    if (rst_n && out_valid && !out_stall)
      board.check_result(result_on_bus);
  end

  // Receiver stall pattern: rotate through modes selected by cycle_count[11:10]
  always @(posedge clk) begin
    cycle_count <= cycle_count + 16'd1;
    case (stall_mode_t'(cycle_count[11:10]))
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_PERIODIC: out_stall <= (cycle_count[4:2] == 3'b101);
      default:        out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_MAX) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic clock_req_t date_request(input logic [7:0] sec, input logic [7:0] min,
                                              input logic [7:0] hour, input logic [7:0] day,
                                              input logic [7:0] month, input logic [7:0] year);
    clock_req_t r;
    r.kind  = REQ_TO_STAMP;
    r.stamp = $urandom();
    r.sec   = sec;
    r.min   = min;
    r.hour  = hour;
    r.day   = day;
    r.month = month;
    r.year  = year;
    return r;
  endfunction

  function automatic clock_req_t stamp_request(input logic [31:0] stamp);
    clock_req_t r;
    r       = date_request(8'($urandom()), 8'($urandom()), 8'($urandom()),
                           8'($urandom()), 8'($urandom()), 8'($urandom()));
    r.kind  = REQ_TO_DATE;
    r.stamp = stamp;
    return r;
  endfunction

  // Mostly well-formed dates and in-range stamps, the rest raw noise
  function automatic clock_req_t random_request();
    clock_req_t  r;
    int unsigned pick, yr, mo, days, rem;
    r    = stamp_request($urandom());
    r.kind = req_kind_t'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    if (r.kind == REQ_TO_STAMP && pick < 7) begin
      yr = $urandom_range(0, 99);
      mo = $urandom_range(1, 12);
      r = date_request(to_bcd($urandom_range(0, 59)), to_bcd($urandom_range(0, 59)),
                       to_bcd($urandom_range(0, 23)),
                       to_bcd($urandom_range(1, month_length(yr, mo - 1))),
                       to_bcd(mo), to_bcd(yr));
    end else if (r.kind == REQ_TO_DATE && pick < 8) begin
      days = $urandom_range(0, DAY_COUNT_END - 1);
      case (pick % 3)
        0:       rem = 0;
        1:       rem = SECS_DAY - 1;
        default: rem = $urandom_range(0, SECS_DAY - 1);
      endcase
      r.stamp = days * SECS_DAY + rem;
    end
    return r;
  endfunction

  task automatic send_request(input clock_req_t r);
    in_valid    <= 1'b1;
    in_req_type <= r.kind;
    in_stamp_in <= r.stamp;
    in_sec_in   <= r.sec;
    in_min_in   <= r.min;
    in_hour_in  <= r.hour;
    in_day_in   <= r.day;
    in_month_in <= r.month;
    in_year_in  <= r.year;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
  endtask

  initial begin
    clock_req_t  directed_q[$];
    int          burst_left;
    int unsigned gap;
    board = new();

    directed_q.push_back(date_request(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00));
    directed_q.push_back(date_request(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99));
    directed_q.push_back(date_request(8'h56, 8'h34, 8'h12, 8'h29, 8'h02, 8'h00));
    directed_q.push_back(date_request(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00));
    directed_q.push_back(date_request(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h00));
    directed_q.push_back(date_request(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01));
    directed_q.push_back(date_request(8'h10, 8'h20, 8'h05, 8'h15, 8'h00, 8'h42));
    directed_q.push_back(date_request(8'h10, 8'h20, 8'h05, 8'h15, 8'h13, 8'h42));
    directed_q.push_back(date_request(8'h10, 8'h20, 8'h05, 8'h00, 8'h06, 8'h42));
    directed_q.push_back(date_request(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    // hex digits above nine still decode as tens plus ones
    directed_q.push_back(date_request(8'h3A, 8'h4F, 8'h1C, 8'h1F, 8'h0A, 8'h7B));
    directed_q.push_back(date_request(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h12, 8'hFF));
    directed_q.push_back(date_request(8'hFF, 8'hFF, 8'hFF, 8'h10, 8'h07, 8'h20));
    directed_q.push_back(date_request(8'h00, 8'h00, 8'h00, 8'h31, 8'h02, 8'h01));
    directed_q.push_back(date_request(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'hA0));
    directed_q.push_back(date_request(8'h00, 8'h00, 8'h00, 8'h01, 8'hF0, 8'h00));
    directed_q.push_back(stamp_request(32'd0));
    directed_q.push_back(stamp_request(DAY_COUNT_END * SECS_DAY - 1));
    directed_q.push_back(stamp_request(DAY_COUNT_END * SECS_DAY));
    directed_q.push_back(stamp_request(32'hFFFF_FFFF));
    directed_q.push_back(stamp_request(59 * SECS_DAY));
    directed_q.push_back(stamp_request(60 * SECS_DAY - 1));
    directed_q.push_back(stamp_request(366 * SECS_DAY));
    directed_q.push_back(stamp_request(32'hAAAA_AAAA));
    directed_q.push_back(stamp_request(32'h5555_5555));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_q[i])
      send_request(directed_q[i]);

    burst_left = 0;
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        if (i >= STEADY_REQUESTS) begin
          gap = $urandom_range(1, 16);
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      send_request(random_request());
    end
    in_valid <= 1'b0;

    // drain, then hold a little longer to catch stray results
    while (board.pending() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (board.mismatches == 0 && board.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
